@@ rtl/double_ended_queue_core_macros.svh @@
// assertion macros shared by the deque checker
`ifndef DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define DQC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("deque check failed");

// next-cycle implication, disabled while reset is asserted
`define DQC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("deque check failed");

`endif

@@ rtl/dq_pkg.sv @@
// shared types and constants of the double-ended queue
package dq_pkg;

	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_BACK  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_BACK   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	localparam logic signed [31:0] EMPTY_FRONT_MARK = -32'sd178;
	localparam logic signed [31:0] EMPTY_BACK_MARK  = -32'sd137;

	// qualified commands broadcast to every cell
	typedef struct packed {
		logic push_front;
		logic push_back;
		logic pop_front;
		logic pop_back;
	} ctl_t;

endpackage

@@ rtl/dq_cell.sv @@
// one cell of the deque chain: a front-ordered and a back-ordered slot
module dq_cell #(
	parameter int IDX = 0,
	parameter int CW  = 5
) (
	input  logic               clk,
	input  dq_pkg::ctl_t       ctl,
	input  logic [CW-1:0]      count,
	input  logic signed [31:0] value,
	input  logic signed [31:0] left_a,
	input  logic signed [31:0] left_b,
	input  logic signed [31:0] right_a,
	input  logic signed [31:0] right_b,
	output logic signed [31:0] a_q,
	output logic signed [31:0] b_q
);
	import dq_pkg::*;

	localparam logic [CW-1:0] IDX_C = CW'(IDX);

	logic at_count;
	assign at_count = (count == IDX_C);

	// a holds entries front first, b holds them back first
	always_ff @(posedge clk) begin
		if (ctl.push_front) begin
			a_q <= (IDX == 0) ? value : left_a;
		end else if (ctl.pop_front) begin
			a_q <= right_a;
		end else if (ctl.push_back && at_count) begin
			a_q <= value;
		end

		if (ctl.push_back) begin
			b_q <= (IDX == 0) ? value : left_b;
		end else if (ctl.pop_back) begin
			b_q <= right_b;
		end else if (ctl.push_front && at_count) begin
			b_q <= value;
		end
	end

endmodule

@@ rtl/double_ended_queue_core.sv @@
// deque core: the result of an accepted transaction is registered straight into the output register
// throughput is one transaction per cycle while m_tready stays high; a held result blocks input
// an accepted push shifts one slot chain and writes the other at the count; a pop shifts one chain
// arst_n clears the entry count and the output valid; slots keep no reset
// slot contents are don't-care until written and are never read before a push writes them
module double_ended_queue_core #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // value[31:0]
	input  logic [1:0]  s_tuser,   // op[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // popped_value[31:0]
	output logic [2:0]  m_tuser    // status[1:0], now_empty[2]
);
	import dq_pkg::*;

	localparam int            CW      = $clog2(DEPTH + 1);
	localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
	localparam logic [CW-1:0] ONE_C   = CW'(1);

	// entry count register
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_next;

	// output register
	logic               m_tvalid_q;
	logic signed [31:0] m_tdata_q;
	logic [2:0]         m_tuser_q;

	// cell chain taps
	logic signed [31:0] a_w [DEPTH];
	logic signed [31:0] b_w [DEPTH];

	op_t                op;
	logic               accept;
	logic               full;
	logic               empty;
	ctl_t               ctl;
	logic signed [31:0] res;
	status_t            status;
	logic               now_empty;

	assign op     = op_t'(s_tuser);
	// take a new transaction unless the held result is still waiting
	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign full     = (count_q == DEPTH_C);
	assign empty    = (count_q == '0);

	// decode the operation; refused pushes and empty pops leave the chain alone
	always_comb begin
		ctl        = '0;
		res        = '0;
		status     = ST_OK;
		count_next = count_q;
		case (op)
			OP_PUSH_FRONT: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					ctl.push_front = accept;
					count_next     = count_q + ONE_C;
				end
			end
			OP_PUSH_BACK: begin
				if (full) begin
					status = ST_FULL;
				end else begin
					ctl.push_back = accept;
					count_next    = count_q + ONE_C;
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					res    = EMPTY_FRONT_MARK;
					status = ST_EMPTY;
				end else begin
					ctl.pop_front = accept;
					res           = a_w[0];
					count_next    = count_q - ONE_C;
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					res    = EMPTY_BACK_MARK;
					status = ST_EMPTY;
				end else begin
					ctl.pop_back = accept;
					res          = b_w[0];
					count_next   = count_q - ONE_C;
				end
			end
			default: begin
				status = ST_OK;
			end
		endcase
	end

	assign now_empty = (count_next == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q    <= count_next;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// result payload, loaded with every accepted transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= res;
			m_tuser_q <= {now_empty, status};
		end
	end

	// row of cells, each linked only to its two neighbors besides the broadcast command, count and value
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [31:0] left_a;
		logic signed [31:0] left_b;
		logic signed [31:0] right_a;
		logic signed [31:0] right_b;

		if (i == 0) begin : g_first
			assign left_a = '0;
			assign left_b = '0;
		end else begin : g_mid_l
			assign left_a = a_w[i-1];
			assign left_b = b_w[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign right_a = '0;
			assign right_b = '0;
		end else begin : g_mid_r
			assign right_a = a_w[i+1];
			assign right_b = b_w[i+1];
		end

		dq_cell #(
			.IDX (i),
			.CW  (CW)
		) u_cell (
			.clk     (clk),
			.ctl     (ctl),
			.count   (count_q),
			.value   (s_tdata),
			.left_a  (left_a),
			.left_b  (left_b),
			.right_a (right_a),
			.right_b (right_b),
			.a_q     (a_w[i]),
			.b_q     (b_w[i])
		);
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

@@ rtl/dq_checker.sv @@
// port-level checker for the deque core, bound to the top level
`include "double_ended_queue_core_macros.svh"

module dq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata,
	input logic [2:0]  m_tuser
);
	import dq_pkg::*;

	logic empty_res;
	logic full_res;

	assign empty_res = m_tvalid && (m_tuser[1:0] == ST_EMPTY);
	assign full_res  = m_tvalid && (m_tuser[1:0] == ST_FULL);

	// a held result does not change until taken
	`DQC_ASSERT_NEXT(a_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	// an empty pop carries a sentinel and leaves the deque empty
	`DQC_ASSERT_IMP(a_empty_pop, clk, arst_n, empty_res, ((m_tdata == EMPTY_FRONT_MARK) || (m_tdata == EMPTY_BACK_MARK)) && m_tuser[2])
	// a refused push returns zero and reports the deque as not empty
	`DQC_ASSERT_IMP(a_full_push, clk, arst_n, full_res, (m_tdata == '0) && !m_tuser[2])
	// no undefined status code reaches the port
	`DQC_ASSERT_IMP(a_status_code, clk, arst_n, m_tvalid, m_tuser[1:0] != 2'd3)

endmodule

bind double_ended_queue_core dq_checker u_dq_checker (.*);
